FILE: hdl/disk_sector_flash_block_cache_top_macros.svh
// Assertion macros used by the sector cache tag module.
`ifndef DISK_SECTOR_FLASH_BLOCK_CACHE_TOP_MACROS_SVH
`define DISK_SECTOR_FLASH_BLOCK_CACHE_TOP_MACROS_SVH

// Property checked at every rising edge of clk, ignored while rst is high.
`define DSFBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge of clk, reset cycles included.
`define DSFBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dsfbc_pkg.sv
package dsfbc_pkg;

  // Disk geometry.
  localparam int SECTORS_PER_TRACK = 26;
  localparam int TRACKS_PER_DISK   = 77;
  localparam int SECTOR_BYTES      = 128;
  localparam int BLOCK_BYTES       = 4096;

  // Field widths.
  localparam int ADDR_W    = 24;
  localparam int PITCH_W   = 20;
  localparam int DISK_W    = 4;
  localparam int NUM_W     = 8;
  localparam int TRACK_W   = $clog2(TRACKS_PER_DISK);
  localparam int SECTOR_W  = $clog2(SECTORS_PER_TRACK);
  localparam int LBA_W     = $clog2(TRACKS_PER_DISK * SECTORS_PER_TRACK);
  localparam int OFF_W     = $clog2(BLOCK_BYTES);
  localparam int BLK_W     = ADDR_W - OFF_W;
  localparam int CFG_IDX_W = 2;

  // Clamp limits at input width.
  localparam logic [NUM_W-1:0] TRACK_MAX  = NUM_W'(TRACKS_PER_DISK - 1);
  localparam logic [NUM_W-1:0] SECTOR_MAX = NUM_W'(SECTORS_PER_TRACK - 1);

  // Configuration reset values.
  localparam logic [ADDR_W-1:0]  BASE_RESET    = 24'h3C0000;
  localparam logic [PITCH_W-1:0] PITCH_RESET   = 20'h3F000;
  localparam logic [DISK_W-1:0]  HIGHEST_RESET = 4'd14;

  // Tag value held after reset; the separate valid bit marks the entry empty.
  localparam logic [BLK_W-1:0] TAG_RESET = '1;

  // Command codes.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE    = 2'd0,
    REG_PITCH   = 2'd1,
    REG_HIGHEST = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_t;

  // Address stage result.
  typedef struct packed {
    func_t             func;
    logic [BLK_W-1:0]  blk;
    logic [OFF_W-1:0]  off;
  } addr_res_t;

  // Result item, first field in the highest bits.
  typedef struct packed {
    logic              dirty_after;
    logic              fill_needed;
    logic [BLK_W-1:0]  writeback_block;
    logic              writeback_needed;
    logic [OFF_W-1:0]  block_offset;
    logic [BLK_W-1:0]  block_number;
  } result_t;

endpackage

FILE: hdl/dsfbc_addr.sv
module dsfbc_addr (
  input  logic                                 clk,
  input  logic                                 ld,
  input  dsfbc_pkg::func_t                     func,
  input  logic [dsfbc_pkg::NUM_W-1:0]          disk,
  input  logic [dsfbc_pkg::NUM_W-1:0]          track,
  input  logic [dsfbc_pkg::NUM_W-1:0]          sector,
  input  logic [dsfbc_pkg::ADDR_W-1:0]         base,
  input  logic [dsfbc_pkg::PITCH_W-1:0]        pitch,
  input  logic [dsfbc_pkg::DISK_W-1:0]         highest,
  output dsfbc_pkg::addr_res_t                 res
);

  logic [dsfbc_pkg::DISK_W-1:0]                  disk_c;
  logic [dsfbc_pkg::TRACK_W-1:0]                 track_c;
  logic [dsfbc_pkg::SECTOR_W-1:0]                sector_c;
  logic [dsfbc_pkg::LBA_W-1:0]                   lba;
  logic [dsfbc_pkg::PITCH_W+dsfbc_pkg::DISK_W-1:0] disk_ofs;
  logic [dsfbc_pkg::ADDR_W-1:0]                  addr;
  dsfbc_pkg::addr_res_t                          res_next;

  // Clamp disk, track and sector to their limits.
  always_comb begin
    if (disk > {{(dsfbc_pkg::NUM_W-dsfbc_pkg::DISK_W){1'b0}}, highest}) begin
      disk_c = highest;
    end else begin
      disk_c = disk[dsfbc_pkg::DISK_W-1:0];
    end
    if (track > dsfbc_pkg::TRACK_MAX) begin
      track_c = dsfbc_pkg::TRACK_MAX[dsfbc_pkg::TRACK_W-1:0];
    end else begin
      track_c = track[dsfbc_pkg::TRACK_W-1:0];
    end
    if (sector > dsfbc_pkg::SECTOR_MAX) begin
      sector_c = dsfbc_pkg::SECTOR_MAX[dsfbc_pkg::SECTOR_W-1:0];
    end else begin
      sector_c = sector[dsfbc_pkg::SECTOR_W-1:0];
    end
  end

  // Flash address wraps modulo the address width.
  always_comb begin
    lba = dsfbc_pkg::LBA_W'(track_c * dsfbc_pkg::LBA_W'(dsfbc_pkg::SECTORS_PER_TRACK))
        + dsfbc_pkg::LBA_W'(sector_c);
    disk_ofs = pitch * disk_c;
    addr = base - disk_ofs[dsfbc_pkg::ADDR_W-1:0]
         + dsfbc_pkg::ADDR_W'(lba * dsfbc_pkg::ADDR_W'(dsfbc_pkg::SECTOR_BYTES));
    res_next.func = func;
    res_next.blk  = addr[dsfbc_pkg::ADDR_W-1:dsfbc_pkg::OFF_W];
    res_next.off  = addr[dsfbc_pkg::OFF_W-1:0];
  end

  // Stage register, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (ld) begin
      res <= res_next;
    end
  end

endmodule

FILE: hdl/dsfbc_tag.sv
`include "disk_sector_flash_block_cache_top_macros.svh"

module dsfbc_tag (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ld,
  input  dsfbc_pkg::addr_res_t  req,
  output dsfbc_pkg::result_t    res
);

  logic [dsfbc_pkg::BLK_W-1:0] tag;
  logic                        tag_valid;
  logic                        dirty;
  logic [dsfbc_pkg::BLK_W-1:0] tag_next;
  logic                        tag_valid_next;
  logic                        dirty_next;
  logic                        hit;
  dsfbc_pkg::result_t          res_next;

  // Tag lookup and write-back decision.
  always_comb begin
    hit            = tag_valid && (req.blk == tag);
    tag_next       = tag;
    tag_valid_next = tag_valid;
    dirty_next     = dirty;
    res_next       = '0;
    case (req.func)
      dsfbc_pkg::FUNC_READ, dsfbc_pkg::FUNC_WRITE: begin
        if (!hit) begin
          res_next.writeback_needed = dirty;
          res_next.writeback_block  = dirty ? tag : '0;
          res_next.fill_needed      = 1'b1;
          tag_next                  = req.blk;
          tag_valid_next            = 1'b1;
          dirty_next                = 1'b0;
        end
        if (req.func == dsfbc_pkg::FUNC_WRITE) begin
          dirty_next = 1'b1;
        end
        res_next.block_number = req.blk;
        res_next.block_offset = req.off;
      end
      dsfbc_pkg::FUNC_FLUSH: begin
        if (dirty) begin
          res_next.writeback_needed = 1'b1;
          res_next.writeback_block  = tag;
          dirty_next                = 1'b0;
        end
        res_next.block_number = tag_valid ? tag : '0;
      end
      default: begin
        res_next.block_number = tag_valid ? tag : '0;
      end
    endcase
    res_next.dirty_after = dirty_next;
  end

  // Cache entry state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag       <= dsfbc_pkg::TAG_RESET;
      tag_valid <= 1'b0;
      dirty     <= 1'b0;
    end else if (ld) begin
      tag       <= tag_next;
      tag_valid <= tag_valid_next;
      dirty     <= dirty_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ld) begin
      res <= res_next;
    end
  end

  // A filled block is the one now held.
  `DSFBC_ASSERT(a_fill_held, ld |=> (!res.fill_needed || (tag_valid && tag == res.block_number)), "fill without matching tag")
  // The reported dirty flag follows the entry state.
  `DSFBC_ASSERT(a_dirty_match, ld |=> (res.dirty_after == dirty), "dirty flag mismatch")
  // A write-back on a miss never targets the block being filled.
  `DSFBC_ASSERT(a_wb_other, ld |=> (!(res.writeback_needed && res.fill_needed) || (res.writeback_block != res.block_number)), "write-back of filled block")
  // Dirty entry always holds a block.
  `DSFBC_ASSERT_ALWAYS(a_dirty_valid, dirty |-> tag_valid, "dirty without a held block")

endmodule

FILE: hdl/disk_sector_flash_block_cache_top.sv
// Each result passes the address stage register and the tag stage register.
// Throughput: one command per cycle while the result side takes transfers.
// The address stage and the tag stage each hold one command; the tag entry
// updates with the result register, so back-to-back commands see the latest entry.
// Reset clears the pipeline, empties the cache entry and restores the
// configuration registers to their defaults.
module disk_sector_flash_block_cache_top (
  input  logic                              clk,
  input  logic                              rst,
  // Command input.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,  // disk[7:0], track[15:8], sector[23:16]
  input  logic [1:0]                        s_tuser,  // func[1:0]
  // Result output.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // block_number[11:0], block_offset[23:12], writeback_needed[24],
  // writeback_block[36:25], fill_needed[37], dirty_after[38], zero pad[39]
  output logic [39:0]                       m_tdata,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [dsfbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsfbc_pkg::ADDR_W-1:0]      cfg_data
);

  logic [dsfbc_pkg::ADDR_W-1:0]  base;
  logic [dsfbc_pkg::PITCH_W-1:0] pitch;
  logic [dsfbc_pkg::DISK_W-1:0]  highest;
  logic                          v1;
  logic                          adv2;
  logic                          ld1;
  logic                          ld2;
  dsfbc_pkg::addr_res_t          s1;
  dsfbc_pkg::result_t            res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base    <= dsfbc_pkg::BASE_RESET;
      pitch   <= dsfbc_pkg::PITCH_RESET;
      highest <= dsfbc_pkg::HIGHEST_RESET;
    end else if (cfg_we) begin
      case (dsfbc_pkg::reg_idx_t'(cfg_index))
        dsfbc_pkg::REG_BASE:    base    <= cfg_data;
        dsfbc_pkg::REG_PITCH:   pitch   <= cfg_data[dsfbc_pkg::PITCH_W-1:0];
        dsfbc_pkg::REG_HIGHEST: highest <= cfg_data[dsfbc_pkg::DISK_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: each stage moves on when the one after it has room.
  assign adv2     = !m_tvalid || m_tready;
  assign s_tready = !v1 || adv2;
  assign ld1      = s_tvalid && s_tready;
  assign ld2      = v1 && adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= 1'b1;
      end else if (ld2) begin
        v1 <= 1'b0;
      end
      if (ld2) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  dsfbc_addr u_addr (
    .clk     (clk),
    .ld      (ld1),
    .func    (dsfbc_pkg::func_t'(s_tuser)),
    .disk    (s_tdata[7:0]),
    .track   (s_tdata[15:8]),
    .sector  (s_tdata[23:16]),
    .base    (base),
    .pitch   (pitch),
    .highest (highest),
    .res     (s1)
  );

  dsfbc_tag u_tag (
    .clk (clk),
    .rst (rst),
    .ld  (ld2),
    .req (s1),
    .res (res)
  );

  assign m_tdata = {1'b0, res};

endmodule

FILE: sim/disk_sector_flash_block_cache_checker.sv
// Watches the command, result and register channels of the sector cache.
// Keeps its own copy of the registers and the cache entry, predicts the
// result of every accepted command and compares each result transfer with
// the oldest prediction.
module disk_sector_flash_block_cache_checker
  import dsfbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [23:0]          s_tdata,  // disk[7:0], track[15:8], sector[23:16]
  input  logic [1:0]           s_tuser,  // func[1:0]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [39:0]          m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  // Register copies.
  logic [ADDR_W-1:0]  base_addr;
  logic [PITCH_W-1:0] pitch;
  logic [DISK_W-1:0]  highest;

  // Cache entry copy: tag, a separate valid bit, and the dirty flag.
  logic [15:0] tag_block;
  logic        tag_valid;
  logic        tag_dirty;

  result_t expected_results[$];

  // Runs one command against the entry copy and returns its result.
  function automatic result_t service_command(func_t op, logic [7:0] disk_in,
                                              logic [7:0] track_in,
                                              logic [7:0] sector_in);
    result_t           r;
    logic [7:0]        d;
    logic [7:0]        t;
    logic [7:0]        s;
    logic [31:0]       lba;
    logic [31:0]       sum;
    logic [ADDR_W-1:0] flash_addr;
    logic [15:0]       blk;
    r = '0;
    if (op == FUNC_READ || op == FUNC_WRITE) begin
      d = (disk_in > {4'd0, highest}) ? {4'd0, highest} : disk_in;
      t = (track_in > TRACK_MAX) ? TRACK_MAX : track_in;
      s = (sector_in > SECTOR_MAX) ? SECTOR_MAX : sector_in;
      lba = 32'(SECTORS_PER_TRACK) * 32'(t) + 32'(s);
      // Disks lie downward from the base; the sum wraps at the flash size.
      sum = 32'(base_addr) - 32'(pitch) * 32'(d) + 32'(SECTOR_BYTES) * lba;
      flash_addr = sum[ADDR_W-1:0];
      blk = 16'(flash_addr / BLOCK_BYTES);
      r.block_offset = OFF_W'(flash_addr % BLOCK_BYTES);
      // A miss writes back a dirty entry and then fills the new block.
      if (!tag_valid || blk != tag_block) begin
        if (tag_dirty) begin
          r.writeback_needed = 1'b1;
          r.writeback_block = tag_block[BLK_W-1:0];
          tag_dirty = 1'b0;
        end
        tag_block = blk;
        tag_valid = 1'b1;
        r.fill_needed = 1'b1;
      end
      if (op == FUNC_WRITE) begin
        tag_dirty = 1'b1;
      end
      r.block_number = blk[BLK_W-1:0];
    end else begin
      // Flush writes back a dirty entry; the idle code changes nothing.
      if (op == FUNC_FLUSH && tag_dirty) begin
        r.writeback_needed = 1'b1;
        r.writeback_block = tag_block[BLK_W-1:0];
        tag_dirty = 1'b0;
      end
      r.block_number = tag_valid ? tag_block[BLK_W-1:0] : '0;
    end
    r.dirty_after = tag_dirty;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [BLK_W-1:0] want,
                             input logic [BLK_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // All three channels are sampled at the rising edge, before the edge's updates.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      base_addr = BASE_RESET;
      pitch = PITCH_RESET;
      highest = HIGHEST_RESET;
      tag_block = 16'hFFFF;
      tag_valid = 1'b0;
      tag_dirty = 1'b0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // Result transfer against the oldest prediction.
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[38:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: result %h arrived with no command outstanding", $time, m_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("block_number", want.block_number, got.block_number);
          check_field("block_offset", want.block_offset, got.block_offset);
          check_field("writeback_needed", 12'(want.writeback_needed),
                      12'(got.writeback_needed));
          check_field("writeback_block", want.writeback_block, got.writeback_block);
          check_field("fill_needed", 12'(want.fill_needed), 12'(got.fill_needed));
          check_field("dirty_after", 12'(want.dirty_after), 12'(got.dirty_after));
        end
      end
      // Register writes; the spare index is ignored.
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BASE:    base_addr = cfg_data;
          REG_PITCH:   pitch = cfg_data[PITCH_W-1:0];
          REG_HIGHEST: highest = cfg_data[DISK_W-1:0];
          default: ;
        endcase
      end
      // Command transfer.
      if (s_tvalid && s_tready) begin
        expected_results.push_back(service_command(func_t'(s_tuser), s_tdata[7:0],
                                                   s_tdata[15:8], s_tdata[23:16]));
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: sim/disk_sector_flash_block_cache_top_tb.sv
module disk_sector_flash_block_cache_top_tb;
  import dsfbc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  int   fail_count;
  int   pending;
  logic quiet = 1'b0;
  logic hold_go = 1'b0;

  // Receiver state.
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int calm_left = 0;

  // Sender state.
  int         send_calm = 0;
  logic [7:0] near_disk = '0;
  logic [7:0] near_track = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  disk_sector_flash_block_cache_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  disk_sector_flash_block_cache_checker result_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Result side: short random stalls, calm stretches, and one long hold-off
  // that lets the pipeline fill up and push back on the command side.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 60;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (quiet || calm_left > 0) begin
      if (calm_left > 0) calm_left--;
      m_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          stall_left = $urandom_range(0, 3);
          m_tready <= 1'b0;
        end
        3: begin
          calm_left = $urandom_range(10, 40);
          m_tready <= 1'b1;
        end
        default: m_tready <= 1'b1;
      endcase
    end
  end

  // Offers one command, possibly after a short gap, and returns at the edge
  // where the transfer happens.
  task automatic issue_command(input func_t op, input logic [7:0] disk,
                               input logic [7:0] track, input logic [7:0] sector);
    int roll;
    roll = $urandom_range(0, 9);
    if (!quiet) begin
      if (send_calm > 0) begin
        send_calm--;
      end else if (roll < 3) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (roll == 3) begin
        send_calm = $urandom_range(10, 40);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {sector, track, disk};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Mostly sectors close to the last position so that the entry gets hits,
  // the rest anywhere in the field ranges.
  task automatic random_command;
    func_t      op;
    logic [7:0] d;
    logic [7:0] t;
    logic [7:0] s;
    int         pick;
    pick = $urandom_range(0, 99);
    op = (pick < 40) ? FUNC_READ : (pick < 75) ? FUNC_WRITE :
         (pick < 92) ? FUNC_FLUSH : FUNC_NONE;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      d = near_disk;
      t = near_track;
      s = 8'($urandom_range(0, 25));
    end else if (pick < 8) begin
      d = near_disk;
      t = near_track + 8'($urandom_range(0, 2));
      s = 8'($urandom_range(0, 31));
      near_disk = 8'($urandom_range(0, 15));
      near_track = 8'($urandom_range(0, 76));
    end else begin
      d = 8'($urandom);
      t = 8'($urandom);
      s = 8'($urandom);
    end
    issue_command(op, d, t, s);
  endtask

  // Writes every register back to back; unused upper data bits are random.
  task automatic program_regs(input logic [23:0] base, input logic [19:0] pitch,
                              input logic [3:0] highest);
    cfg_we <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_PITCH;
    cfg_data <= {4'($urandom), pitch};
    @(posedge clk);
    cfg_index <= REG_HIGHEST;
    cfg_data <= {20'($urandom), highest};
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data <= 24'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stops offering commands and waits for every result plus the pipeline depth.
  task automatic wait_idle;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [23:0] base;
    logic [19:0] pitch;
    logic [3:0]  highest;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Nothing held yet: flush and the idle code report block zero.
    issue_command(FUNC_FLUSH, 8'd0, 8'd0, 8'd0);
    issue_command(FUNC_NONE, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();

    // Top of flash: the first block equals the reset tag, and addresses wrap.
    program_regs(24'hFFFFFF, 20'h0, 4'd0);
    issue_command(FUNC_READ, 8'd0, 8'd0, 8'd0);
    issue_command(FUNC_WRITE, 8'd0, 8'd0, 8'd0);
    issue_command(FUNC_READ, 8'd5, 8'd0, 8'd1);
    issue_command(FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF);
    issue_command(FUNC_FLUSH, 8'd0, 8'd0, 8'd0);
    issue_command(FUNC_FLUSH, 8'd0, 8'd0, 8'd0);
    issue_command(FUNC_NONE, 8'd0, 8'd0, 8'd0);
    issue_command(FUNC_WRITE, 8'd0, 8'd76, 8'd25);
    issue_command(FUNC_NONE, 8'd3, 8'd7, 8'd9);
    issue_command(FUNC_READ, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // Largest pitch from a zero base: disks wrap below address zero.
    program_regs(24'h0, 20'hFFFFF, 4'd15);
    issue_command(FUNC_READ, 8'd15, 8'd0, 8'd0);
    issue_command(FUNC_WRITE, 8'd200, 8'd76, 8'd25);
    issue_command(FUNC_READ, 8'd0, 8'd77, 8'd26);
    issue_command(FUNC_WRITE, 8'd0, 8'd76, 8'd25);
    issue_command(FUNC_WRITE, 8'd14, 8'd128, 8'd128);
    issue_command(FUNC_FLUSH, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // Power-on layout written back explicitly.
    program_regs(BASE_RESET, PITCH_RESET, HIGHEST_RESET);
    issue_command(FUNC_READ, 8'd14, 8'd0, 8'd0);
    issue_command(FUNC_WRITE, 8'd0, 8'd76, 8'd25);
    issue_command(FUNC_READ, 8'd15, 8'd0, 8'd0);
    issue_command(FUNC_FLUSH, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 3))
        0: base = 24'h0;
        1: base = 24'hFFFFFF;
        2: base = BASE_RESET;
        default: base = 24'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: pitch = 20'h0;
        1: pitch = 20'hFFFFF;
        2: pitch = PITCH_RESET;
        default: pitch = 20'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: highest = 4'd0;
        1: highest = 4'd14;
        2: highest = 4'd15;
        default: highest = 4'($urandom);
      endcase
      if (phase == 5) quiet <= 1'b1;
      program_regs(base, pitch, highest);
      if (phase == 1) hold_go <= 1'b1;
      repeat (105) random_command();
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("** disk_sector_flash_block_cache_top: PASSED **");
    end else begin
      $display("** disk_sector_flash_block_cache_top: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("** disk_sector_flash_block_cache_top: FAILED **");
    $finish;
  end

endmodule
